// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the RTL of the SHA-256 stream hasher.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is held.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked check that also holds while reset is held.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hw/rtl/sha256s_pkg.sv =====
// Package with the types, codes and constant tables of the SHA-256 stream hasher.
`default_nettype none

package sha256s_pkg;

  // Command codes carried on the input tuser.
  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  localparam int BLOCK_BYTES  = 64;
  localparam int ROUNDS       = 64;
  localparam int LEN_POS      = 56;  // first byte of the length field in the last block
  localparam logic [7:0] PAD_MARK = 8'h80;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_FINAL,
    ST_EMIT
  } state_t;

  typedef logic [31:0] word_t;

  localparam word_t K_TABLE [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam word_t H0_TABLE [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic word_t rotr(input word_t x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t big_sigma0(input word_t x);
    big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sha256_stream_hasher.sv =====
// Top level of the SHA-256 stream hasher: byte intake, padding, round unit and digest output.
`default_nettype none

// SHA-256 hasher fed one message byte per input beat. A beat with tuser at the
// append code carries a byte in tdata; a beat with tuser at the finish code
// closes the message, and the block then sends the eight digest words, most
// significant word first, each with its index, tlast on the eighth and the
// sticky length-error flag in tuser, after which it is ready for a new
// message. Every 64th byte fills the block and starts a compression: 64
// rounds, then the chaining add. A finish shifts in padding bytes up to
// the end of the block, runs one or two compressions (two when 56 or more
// bytes already sit in the block), and then sends the eight output beats
// at the pace the receiver sets. The single round unit does one SHA-256
// round per cycle, and the block shift register takes one byte per cycle
// during padding and, while appending, whenever the sender offers a byte.
// The input is not ready while a compression, padding or digest output is
// under way. Bytes appended once 2^61-1 bytes have been taken are dropped
// and flag a length error that is reported with the digest and then cleared.
module sha256_stream_hasher import sha256s_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  input  wire logic        s_tuser,   // [0] command
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // [31:0] digest_word, [34:32] word_index, rest zero
  output logic             m_tuser,   // [0] length_error
  output logic             m_tlast    // last digest word
);

  `include "assert_macros.svh"

  state_t       state, state_next;

  // Message block: sixteen 32-bit words, w[0] the oldest. Bytes shift in at
  // the bottom, and during the rounds it slides one word per round as the
  // message schedule window.
  word_t        w [16];
  word_t        v [8];      // working variables a to h
  word_t        chain [8];

  logic [5:0]   fill;       // bytes in the current block
  logic [60:0]  byte_count;
  logic         overflow;
  logic [5:0]   round;
  logic [2:0]   idx;        // digest word being sent
  logic         finishing;
  logic         mark_sent;
  logic         len_blk;    // current padding block carries the length field
  logic [63:0]  bit_len;

  logic         in_beat;
  logic         out_beat;
  logic         append_ok;
  logic [7:0]   pad_byte;
  word_t        t1, t2, w_new;

  assign in_beat   = s_tvalid && s_tready;
  assign out_beat  = m_tvalid && m_tready;
  assign append_ok = (s_tuser == CMD_APPEND) && !(&byte_count);

  // Padding bytes: the marker first, then zeros, with the big-endian bit
  // length filling the last eight bytes of the final block.
  always_comb begin
    if (!mark_sent) begin
      pad_byte = PAD_MARK;
    end else if (len_blk && (fill >= 6'(LEN_POS))) begin
      pad_byte = bit_len[{~fill[2:0], 3'b000} +: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  // The shared round unit and the schedule expansion.
  always_comb begin
    t1 = v[7] + big_sigma1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6]))
       + K_TABLE[round] + w[0];
    t2 = big_sigma0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
    w_new = small_sigma1(w[14]) + w[9] + small_sigma0(w[1]) + w[0];
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_beat) begin
          if (s_tuser == CMD_FINISH) begin
            state_next = ST_PAD;
          end else if (append_ok && (fill == 6'(BLOCK_BYTES - 1))) begin
            state_next = ST_ROUND;
          end
        end
      end
      ST_PAD: begin
        if (fill == 6'(BLOCK_BYTES - 1)) begin
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (round == 6'(ROUNDS - 1)) begin
          state_next = ST_FINAL;
        end
      end
      ST_FINAL: begin
        if (finishing && !len_blk) begin
          state_next = ST_PAD;
        end else if (finishing) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (m_tready && (idx == 3'd7)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Port outputs.
  always_comb begin
    s_tready = (state == ST_IDLE);
    m_tvalid = (state == ST_EMIT);
    m_tdata  = {5'b0, idx, chain[idx]};
    m_tuser  = overflow;
    m_tlast  = (idx == 3'd7);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      fill       <= '0;
      byte_count <= '0;
      overflow   <= 1'b0;
      round      <= '0;
      idx        <= '0;
      finishing  <= 1'b0;
      mark_sent  <= 1'b0;
      len_blk    <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        chain[i] <= H0_TABLE[i];
      end
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: begin
          if (in_beat) begin
            if (s_tuser == CMD_FINISH) begin
              bit_len   <= {byte_count, 3'b000};
              finishing <= 1'b1;
              mark_sent <= 1'b0;
              len_blk   <= (fill < 6'(LEN_POS));
            end else if (append_ok) begin
              for (int i = 0; i < 15; i++) begin
                w[i] <= {w[i][23:0], w[i+1][31:24]};
              end
              w[15]      <= {w[15][23:0], s_tdata};
              fill       <= fill + 6'd1;
              byte_count <= byte_count + 61'd1;
              if (fill == 6'(BLOCK_BYTES - 1)) begin
                round <= '0;
                for (int i = 0; i < 8; i++) begin
                  v[i] <= chain[i];
                end
              end
            end else begin
              overflow <= 1'b1;
            end
          end
        end
        ST_PAD: begin
          for (int i = 0; i < 15; i++) begin
            w[i] <= {w[i][23:0], w[i+1][31:24]};
          end
          w[15]     <= {w[15][23:0], pad_byte};
          fill      <= fill + 6'd1;
          mark_sent <= 1'b1;
          if (fill == 6'(BLOCK_BYTES - 1)) begin
            round <= '0;
            for (int i = 0; i < 8; i++) begin
              v[i] <= chain[i];
            end
          end
        end
        ST_ROUND: begin
          for (int i = 0; i < 15; i++) begin
            w[i] <= w[i+1];
          end
          w[15] <= w_new;
          v[0]  <= t1 + t2;
          v[1]  <= v[0];
          v[2]  <= v[1];
          v[3]  <= v[2];
          v[4]  <= v[3] + t1;
          v[5]  <= v[4];
          v[6]  <= v[5];
          v[7]  <= v[6];
          round <= round + 6'd1;
        end
        ST_FINAL: begin
          for (int i = 0; i < 8; i++) begin
            chain[i] <= chain[i] + v[i];
          end
          if (finishing) begin
            len_blk <= 1'b1;
            idx     <= '0;
          end
        end
        ST_EMIT: begin
          if (m_tready) begin
            idx <= idx + 3'd1;
            if (idx == 3'd7) begin
              // Message closed: back to the initial hash state.
              fill       <= '0;
              byte_count <= '0;
              overflow   <= 1'b0;
              finishing  <= 1'b0;
              mark_sent  <= 1'b0;
              len_blk    <= 1'b0;
              for (int i = 0; i < 8; i++) begin
                chain[i] <= H0_TABLE[i];
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  `ASSERT_CLK(a_no_overlap, !(s_tready && m_tvalid), "input ready while digest is sent")
  `ASSERT_CLK(a_round_idle, (state != ST_ROUND) |-> (round == 6'd0), "round counter left running")
  `ASSERT_CLK(a_restart, (out_beat && m_tlast) |=> (s_tready && (byte_count == 61'd0) && !overflow), "no restart after digest")
  `ASSERT_CLK(a_drop, (in_beat && (s_tuser == CMD_APPEND) && (&byte_count)) |=> (overflow && $stable(byte_count)), "byte past the length limit not dropped")

endmodule

`default_nettype wire

// ===== tb/sha256_digest_checker.sv =====
// Checker for the SHA-256 stream hasher: follows both streams, predicts and compares digests.
`timescale 1ns / 100ps

module sha256_digest_checker import sha256s_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,
  input  logic        m_tuser,
  input  logic        m_tlast,
  output int          fail_count,
  output int          pending_words,
  output int          words_checked
);

  typedef struct packed {
    word_t      value;
    logic [2:0] position;
    logic       is_last;
    logic       len_err;
  } digest_beat_t;

  localparam int MAX_REPORTS = 30;

  // Running hash state of the message in progress.
  word_t       chain_h [8];
  logic [7:0]  block_buf [BLOCK_BYTES];
  logic [5:0]  fill;
  logic [60:0] msg_bytes;
  logic        len_overflow;

  digest_beat_t expected_words [$];

  initial begin
    fail_count    = 0;
    pending_words = 0;
    words_checked = 0;
  end

  function automatic word_t ror32(input word_t x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void restart_hash();
    for (int i = 0; i < 8; i++) chain_h[i] = H0_TABLE[i];
    fill         = '0;
    msg_bytes    = '0;
    len_overflow = 1'b0;
  endfunction

  // One 64-round compression of block_buf into chain_h.
  function automatic void compress_block();
    word_t sched [64];
    word_t v [8];
    word_t s0, s1, t1, t2;
    for (int t = 0; t < 16; t++)
      sched[t] = {block_buf[4*t], block_buf[4*t+1], block_buf[4*t+2], block_buf[4*t+3]};
    for (int t = 16; t < 64; t++) begin
      s0 = ror32(sched[t-15], 7) ^ ror32(sched[t-15], 18) ^ (sched[t-15] >> 3);
      s1 = ror32(sched[t-2], 17) ^ ror32(sched[t-2], 19) ^ (sched[t-2] >> 10);
      sched[t] = s1 + sched[t-7] + s0 + sched[t-16];
    end
    for (int i = 0; i < 8; i++) v[i] = chain_h[i];
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TABLE[t] + sched[t];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain_h[i] = chain_h[i] + v[i];
  endfunction

  // A byte past the length limit is dropped and only sets the sticky error.
  function automatic void absorb_byte(input logic [7:0] value);
    if (msg_bytes == '1) begin
      len_overflow = 1'b1;
    end else begin
      block_buf[fill] = value;
      fill      = fill + 6'd1;
      msg_bytes = msg_bytes + 61'd1;
      if (fill == '0) compress_block();
    end
  endfunction

  // Pads the message, runs the final compressions and queues the eight digest words.
  function automatic void close_message();
    logic [63:0]  bit_len;
    int           pos;
    digest_beat_t beat;
    bit_len = {msg_bytes, 3'b000};
    pos = fill;
    block_buf[pos] = PAD_MARK;
    pos++;
    if (pos > LEN_POS) begin
      while (pos < BLOCK_BYTES) begin
        block_buf[pos] = 8'h00;
        pos++;
      end
      compress_block();
      pos = 0;
    end
    while (pos < LEN_POS) begin
      block_buf[pos] = 8'h00;
      pos++;
    end
    for (int i = 0; i < 8; i++) block_buf[LEN_POS + i] = bit_len[63 - 8*i -: 8];
    compress_block();
    for (int i = 0; i < 8; i++) begin
      beat.value    = chain_h[i];
      beat.position = 3'(i);
      beat.is_last  = (i == 7);
      beat.len_err  = len_overflow;
      expected_words.push_back(beat);
    end
    restart_hash();
  endfunction

  task automatic report_mismatch(input string what);
    if (fail_count < MAX_REPORTS) $display("%0t ns checker: %s", $realtime, what);
    fail_count++;
  endtask

  task automatic check_digest_beat();
    digest_beat_t want;
    if (expected_words.size() == 0) begin
      report_mismatch($sformatf("digest beat %h with no digest pending", m_tdata));
      return;
    end
    want = expected_words.pop_front();
    if (m_tdata[31:0] !== want.value)
      report_mismatch($sformatf("word %0d: digest word %h, expected %h",
                                want.position, m_tdata[31:0], want.value));
    if (m_tdata[34:32] !== want.position)
      report_mismatch($sformatf("word %0d: word index %0d", want.position, m_tdata[34:32]));
    if (m_tdata[39:35] !== 5'b0)
      report_mismatch($sformatf("word %0d: padding bits %b", want.position, m_tdata[39:35]));
    if (m_tlast !== want.is_last)
      report_mismatch($sformatf("word %0d: tlast %b, expected %b",
                                want.position, m_tlast, want.is_last));
    if (m_tuser !== want.len_err)
      report_mismatch($sformatf("word %0d: length error %b, expected %b",
                                want.position, m_tuser, want.len_err));
    words_checked++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      restart_hash();
      expected_words.delete();
    end else begin
      if (s_tvalid && s_tready) begin
        if (s_tuser == CMD_FINISH) close_message();
        else absorb_byte(s_tdata);
      end
      if (m_tvalid && m_tready) check_digest_beat();
    end
    pending_words = expected_words.size();
  end

endmodule

// ===== tb/testbench.sv =====
// Top of the SHA-256 stream hasher testbench: clock, reset, stimulus, pacing and verdict.
`timescale 1ns / 100ps

module testbench;
  import sha256s_pkg::*;

  // Generous bound on the whole run.
  localparam int CYCLE_LIMIT = 400000;
  // Quiet cycles after the last expected word, to catch stray output beats.
  localparam int DRAIN_CYCLES = 300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // [7:0] data_byte
  logic        s_tuser = CMD_APPEND;   // [0] command
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;   // [31:0] digest_word, [34:32] word_index, rest zero
  logic        m_tuser;   // [0] length_error
  logic        m_tlast;

  int fail_count;
  int pending_words;
  int words_checked;

  // Pacing of the two sides, in percent of cycles, changed from phase to phase.
  int idle_pct  = 0;
  int stall_pct = 0;

  int cycle_count = 0;
  int beats_sent  = 0;
  int bytes_sent  = 0;
  int messages    = 0;

  // The length limit lies at 2^61-1 bytes, so the error flag cannot be provoked in a
  // run of this size; the checker still models it and expects it to stay clear.
  int boundary_len [4] = '{120, 0, 0, 0};

  sha256_stream_hasher dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  sha256_digest_checker digest_chk (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tuser       (m_tuser),
    .m_tlast       (m_tlast),
    .fail_count    (fail_count),
    .pending_words (pending_words),
    .words_checked (words_checked)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // The receiver decides afresh at every falling edge whether to take a beat.
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog: a hung handshake or a missing digest ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // Offers one beat from a falling edge and holds it until the block takes it.
  // Before the offer the sender may sit idle for a random number of cycles.
  // Valid stays high between back-to-back beats, so it is set at most once per step.
  task automatic offer_beat(input logic cmd, input logic [7:0] value);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = cmd;
    s_tdata  = value;
    do @(posedge clk); while (!s_tready);
    beats_sent++;
    if (cmd == CMD_APPEND) bytes_sent++;
    @(negedge clk);
  endtask

  // A message of random bytes closed by a finish beat. The finish beat carries a
  // random byte too, which the block has to ignore.
  task automatic hash_random_message(input int n_bytes);
    for (int i = 0; i < n_bytes; i++) offer_beat(CMD_APPEND, 8'($urandom_range(255)));
    offer_beat(CMD_FINISH, 8'($urandom_range(255)));
    messages++;
  endtask

  initial begin
    int phase_bytes;
    int msg_len;

    // Reset is held from the start and released on a falling edge.
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part, no idling: the empty message, twice in a row, then the
    // familiar three-byte message and the two extreme byte values alone.
    offer_beat(CMD_FINISH, 8'h00);
    offer_beat(CMD_FINISH, 8'hff);
    offer_beat(CMD_APPEND, 8'h61);
    offer_beat(CMD_APPEND, 8'h62);
    offer_beat(CMD_APPEND, 8'h63);
    offer_beat(CMD_FINISH, 8'h00);
    offer_beat(CMD_APPEND, 8'h00);
    offer_beat(CMD_FINISH, 8'h00);
    offer_beat(CMD_APPEND, 8'hff);
    offer_beat(CMD_FINISH, 8'hff);
    messages += 5;

    // Random part in four pacing phases. The first phase starts with a long
    // message: its first 64 bytes fill a block and start a compression, and the
    // 56 bytes left over no longer leave room for the length, so the finish
    // needs a second padding block. Short messages of random length follow.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 65; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 65; end
        default: begin idle_pct = 26; stall_pct = 26; end
      endcase
      if (boundary_len[phase] != 0) hash_random_message(boundary_len[phase]);
      phase_bytes = 0;
      while (phase_bytes < 5) begin
        msg_len = $urandom_range(0, 12);
        hash_random_message(msg_len);
        phase_bytes += msg_len + 1;
      end
    end
    s_tvalid = 1'b0;

    // Wait for every digest word, then a quiet spell for anything unasked.
    while (pending_words != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run summary: %0d messages (%0d bytes, %0d input beats) hashed over four",
             messages, bytes_sent, beats_sent);
    $display("pacing phases; %0d digest words compared, %0d mismatches.",
             words_checked, fail_count);
    if (fail_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/sha256s_pkg.sv
hw/rtl/sha256_stream_hasher.sv
tb/sha256_digest_checker.sv
tb/testbench.sv
